### rtl/core/tcw_pkg.sv
// tcw_pkg: shared types and constants of the text console writer.
// Used by tcw_ctrl, tcw_datapath and the text_console_writer top level.
`default_nettype none

package tcw_pkg;

    localparam int FUNC_W = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int POS_W  = 11;
    localparam int OCOL_W = 7;
    localparam int OROW_W = 5;
    localparam int ATTR_W = 8;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_BACK  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_READ  = 2'd3
    } t_func;

    // controller -> datapath
    typedef struct packed {
        logic capture;      // latch the input item
        logic exec;         // run the item: cursor update, char write, cell read
        logic sweep_rst;    // restart the grid sweep counter
        logic sweep_blank;  // write a space at the sweep cell, advance
        logic scroll_copy;  // copy one cell up by a row, advance
        logic load_out;     // load the result register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic func_clear;
        logic need_scroll;
        logic sweep_last;
        logic copy_last;
    } t_dp_sts;

endpackage

`default_nettype wire

### rtl/core/tcw_ctrl.sv
// tcw_ctrl: sequencing FSM of the text console writer.
// Depends on tcw_pkg; drives tcw_datapath through t_dp_cmd / t_dp_sts.
`default_nettype none

module tcw_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    input  tcw_pkg::t_dp_sts     i_sts,
    output tcw_pkg::t_dp_cmd     o_cmd
);
    import tcw_pkg::*;

    typedef enum logic [6:0] {
        ST_INIT   = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_EXEC   = 7'b0000100,
        ST_CLEAR  = 7'b0001000,
        ST_SCROLL = 7'b0010000,
        ST_BLANK  = 7'b0100000,
        ST_DONE   = 7'b1000000
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    logic    in_ready;
    logic    out_free;
    t_dp_cmd cmd;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state  = r_state;
        cmd      = '0;
        in_ready = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                cmd.sweep_blank = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (i_sts.func_clear) begin
                    cmd.sweep_rst = 1'b1;
                    n_state       = ST_CLEAR;
                end else if (i_sts.need_scroll) begin
                    cmd.sweep_rst = 1'b1;
                    n_state       = ST_SCROLL;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_CLEAR: begin
                cmd.sweep_blank = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_SCROLL: begin
                cmd.scroll_copy = 1'b1;
                if (i_sts.copy_last) begin
                    n_state = ST_BLANK;
                end
            end
            ST_BLANK: begin
                cmd.sweep_blank = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // result waits here until the output register is free
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    in_ready     = 1'b1;
                    if (i_in_valid) begin
                        cmd.capture = 1'b1;
                        n_state     = ST_EXEC;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    assign n_out_valid = cmd.load_out || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = !in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

`default_nettype wire

### rtl/core/tcw_datapath.sv
// tcw_datapath: character grid memory, cursor, sweep counter and result register.
// Depends on tcw_pkg; commanded by tcw_ctrl.
`default_nettype none

module tcw_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  tcw_pkg::t_dp_cmd                  i_cmd,
    output tcw_pkg::t_dp_sts                  o_sts,
    input  wire logic [tcw_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [tcw_pkg::CHAR_W-1:0]   i_char_code,
    input  wire logic [tcw_pkg::IDX_W-1:0]    i_cell_index,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [tcw_pkg::ATTR_W-1:0]   i_cfg_wr_data,
    output logic [tcw_pkg::POS_W-1:0]         o_cursor_position,
    output logic [tcw_pkg::OCOL_W-1:0]        o_cursor_col,
    output logic [tcw_pkg::OROW_W-1:0]        o_cursor_row,
    output logic [tcw_pkg::CHAR_W-1:0]        o_read_char,
    output logic [tcw_pkg::ATTR_W-1:0]        o_read_attribute
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);

    localparam logic [COL_W-1:0] COL_LAST   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [AW-1:0]    ADDR_COLS  = AW'(COLUMNS);
    localparam logic [AW-1:0]    ADDR_LAST  = AW'(CELLS - 1);
    localparam logic [AW-1:0]    COPY_LAST  = AW'(CELLS - COLUMNS);

    logic [CHAR_W-1:0] r_cells [CELLS];

    t_func             r_func;
    logic [CHAR_W-1:0] r_char;
    logic [IDX_W-1:0]  r_idx;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [AW-1:0]     r_pos, n_pos;
    logic [AW-1:0]     r_sweep;
    logic [ATTR_W-1:0] r_attr;
    logic [CHAR_W-1:0] r_rdata;
    logic              r_rd_ok;

    logic [POS_W-1:0]  r_o_pos;
    logic [OCOL_W-1:0] r_o_col;
    logic [OROW_W-1:0] r_o_row;
    logic [CHAR_W-1:0] r_o_char;
    logic [ATTR_W-1:0] r_o_attr;

    logic              need_scroll;
    logic              ex_we;
    logic [AW-1:0]     ex_waddr;
    logic [AW-1:0]     col_ext;
    logic              idx_ok;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CHAR_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    assign col_ext = AW'(r_col);
    assign idx_ok  = (32'(r_idx) < CELLS);

    // cursor step for the captured item; r_pos tracks row * COLUMNS + col
    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_pos       = r_pos;
        need_scroll = 1'b0;
        ex_we       = 1'b0;
        ex_waddr    = r_pos;
        unique case (r_func)
            FUNC_PUT: begin
                if (r_char == CHAR_LF || r_char == CHAR_CR) begin
                    n_col = '0;
                    if (r_row != ROW_LAST) begin
                        n_row = r_row + ROW_W'(1);
                        n_pos = r_pos - col_ext + ADDR_COLS;
                    end else begin
                        need_scroll = 1'b1;
                        n_pos       = r_pos - col_ext;
                    end
                end else if (r_char != CHAR_NUL) begin
                    ex_we = 1'b1;
                    if (r_col == COL_LAST) begin
                        n_col = '0;
                        if (r_row != ROW_LAST) begin
                            n_row = r_row + ROW_W'(1);
                            n_pos = r_pos + AW'(1);
                        end else begin
                            need_scroll = 1'b1;
                            n_pos       = r_pos - col_ext;
                        end
                    end else begin
                        n_col = r_col + COL_W'(1);
                        n_pos = r_pos + AW'(1);
                    end
                end
            end
            FUNC_BACK: begin
                ex_we = 1'b1;
                if (r_col != '0) begin
                    n_col = r_col - COL_W'(1);
                    n_pos = r_pos - AW'(1);
                end else if (r_row != '0) begin
                    n_col = COL_LAST;
                    n_row = r_row - ROW_W'(1);
                    n_pos = r_pos - AW'(1);
                end
                ex_waddr = n_pos;
            end
            FUNC_CLEAR: begin
                n_col = '0;
                n_row = '0;
                n_pos = '0;
            end
            FUNC_READ: begin
            end
            default: begin
            end
        endcase
    end

    // one write port: item write, blank fill, or the copy of the cell read last cycle
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_sweep;
        mem_wdata = CHAR_BLANK;
        mem_re    = 1'b0;
        mem_raddr = r_sweep + ADDR_COLS;
        priority if (i_cmd.exec) begin
            mem_we    = ex_we;
            mem_waddr = ex_waddr;
            mem_wdata = r_char;
            mem_re    = (r_func == FUNC_READ) && idx_ok;
            mem_raddr = AW'(r_idx);
        end else if (i_cmd.sweep_blank) begin
            mem_we = 1'b1;
        end else if (i_cmd.scroll_copy) begin
            mem_we    = (r_sweep != '0);
            mem_waddr = r_sweep - AW'(1);
            mem_wdata = r_rdata;
            mem_re    = (r_sweep != COPY_LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_cells[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_cells[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_pos   <= '0;
            r_sweep <= '0;
            r_attr  <= ATTR_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_attr <= i_cfg_wr_data;
            end
            if (i_cmd.exec) begin
                r_col <= n_col;
                r_row <= n_row;
                r_pos <= n_pos;
            end
            if (i_cmd.sweep_rst) begin
                r_sweep <= '0;
            end else if (i_cmd.sweep_blank) begin
                r_sweep <= r_sweep + AW'(1);
            end else if (i_cmd.scroll_copy && r_sweep != COPY_LAST) begin
                // hold at the first cell of the last row for the blank fill
                r_sweep <= r_sweep + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= t_func'(i_func);
            r_char <= i_char_code;
            r_idx  <= i_cell_index;
        end
        if (i_cmd.exec) begin
            r_rd_ok <= (r_func == FUNC_READ) && idx_ok;
        end
        if (i_cmd.load_out) begin
            r_o_pos  <= POS_W'(r_pos);
            r_o_col  <= OCOL_W'(r_col);
            r_o_row  <= OROW_W'(r_row);
            r_o_char <= r_rd_ok ? r_rdata : '0;
            r_o_attr <= r_rd_ok ? r_attr : '0;
        end
    end

    assign o_sts.func_clear  = (r_func == FUNC_CLEAR);
    assign o_sts.need_scroll = need_scroll;
    assign o_sts.sweep_last  = (r_sweep == ADDR_LAST);
    assign o_sts.copy_last   = (r_sweep == COPY_LAST);

    assign o_cursor_position = r_o_pos;
    assign o_cursor_col      = r_o_col;
    assign o_cursor_row      = r_o_row;
    assign o_read_char       = r_o_char;
    assign o_read_attribute  = r_o_attr;

endmodule

`default_nettype wire

### rtl/core/text_console_writer.sv
// Text console writer: a ROWS x COLUMNS grid of character cells with a cursor. Each
// transfer on the input carries func (put, back-put, clear, read) and gives one result
// with the cursor after the operation and, for a read, the cell byte and the attribute.
// Put, back-put and read go through an execute step and then a result step, as the read
// of the grid memory is registered; the input is stalled until the result is loaded. A
// put or newline that scrolls first moves the rows up (one cell moved per cycle through
// the memory, then the last row blanked); clear blanks every cell. After reset the grid
// is blanked by a pass over all ROWS*COLUMNS cells during which the input is stalled;
// attribute writes are taken at any time.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [tcw_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [tcw_pkg::CHAR_W-1:0]   i_char_code,
    input  wire logic [tcw_pkg::IDX_W-1:0]    i_cell_index,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [tcw_pkg::POS_W-1:0]         o_cursor_position,
    output logic [tcw_pkg::OCOL_W-1:0]        o_cursor_col,
    output logic [tcw_pkg::OROW_W-1:0]        o_cursor_row,
    output logic [tcw_pkg::CHAR_W-1:0]        o_read_char,
    output logic [tcw_pkg::ATTR_W-1:0]        o_read_attribute,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [tcw_pkg::ATTR_W-1:0]   i_cfg_wr_data
);
    import tcw_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_func            (i_func),
        .i_char_code       (i_char_code),
        .i_cell_index      (i_cell_index),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .o_cursor_position (o_cursor_position),
        .o_cursor_col      (o_cursor_col),
        .o_cursor_row      (o_cursor_row),
        .o_read_char       (o_read_char),
        .o_read_attribute  (o_read_attribute)
    );

endmodule

`default_nettype wire

### rtl/core/tcw_check.sv
// tcw_check: port-level assertions for text_console_writer, attached by bind.
// Depends on tcw_pkg for field widths.
`default_nettype none

module tcw_check #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_stall,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_stall,
    input wire logic [tcw_pkg::POS_W-1:0]    o_cursor_position,
    input wire logic [tcw_pkg::OCOL_W-1:0]   o_cursor_col,
    input wire logic [tcw_pkg::OROW_W-1:0]   o_cursor_row,
    input wire logic [tcw_pkg::CHAR_W-1:0]   o_read_char,
    input wire logic [tcw_pkg::ATTR_W-1:0]   o_read_attribute
);
    import tcw_pkg::*;

    // a result held back by stall keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cursor_position)
            && $stable(o_cursor_col) && $stable(o_cursor_row)
            && $stable(o_read_char) && $stable(o_read_attribute))
        else $error("result payload changed while stalled");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_cursor_col) < COLUMNS) && (32'(o_cursor_row) < ROWS))
        else $error("cursor outside the grid");

    a_pos_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (ROWS <= 32) && (ROWS * COLUMNS <= 2048) |->
            o_cursor_position == POS_W'(32'(o_cursor_row) * COLUMNS + 32'(o_cursor_col)))
        else $error("cursor position disagrees with row and column");

    // one item at a time: the cycle after an input transfer is always stalled
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while previous item executes");

endmodule

bind text_console_writer tcw_check #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_tcw_check (.*);

`default_nettype wire

### tb/tb_text_console_writer.sv
// Self-checking testbench for text_console_writer: a cell grid and cursor predictor,
// a queue-fed input driver and a result monitor with random gaps and stalls.
// Depends on tcw_pkg and the text_console_writer RTL.
`timescale 1ns / 100ps

module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int COLS       = 80;
    localparam int ROWS       = 25;
    localparam int CELLS      = COLS * ROWS;
    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD  = 600;

    typedef struct packed {
        t_func              func;
        logic [CHAR_W-1:0]  ch;
        logic [IDX_W-1:0]   idx;
    } t_console_cmd;

    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [OCOL_W-1:0]  col;
        logic [OROW_W-1:0]  row;
        logic [CHAR_W-1:0]  rd_char;
        logic [ATTR_W-1:0]  rd_attr;
    } t_cursor_report;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               out_stall = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [ATTR_W-1:0]  cfg_wr_data = '0;
    t_console_cmd       drive_cmd = '0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic [POS_W-1:0]   o_cursor_position;
    logic [OCOL_W-1:0]  o_cursor_col;
    logic [OROW_W-1:0]  o_cursor_row;
    logic [CHAR_W-1:0]  o_read_char;
    logic [ATTR_W-1:0]  o_read_attribute;

    // shadow of the screen
    logic [CHAR_W-1:0]  grid_model [0:CELLS-1];
    int                 cur_col;
    int                 cur_row;
    logic [ATTR_W-1:0]  attr_model;

    t_console_cmd       pending_cmds [$];
    t_cursor_report     expected_reports [$];
    int                 mismatches = 0;
    int                 results_seen = 0;
    int                 queued_total = 0;
    bit                 idle_on = 1'b0;
    int                 gap_left = 0;
    int                 quiet_cycles = 0;

    text_console_writer #(
        .COLUMNS(COLS),
        .ROWS   (ROWS)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (drive_cmd.func),
        .i_char_code      (drive_cmd.ch),
        .i_cell_index     (drive_cmd.idx),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_cursor_position(o_cursor_position),
        .o_cursor_col     (o_cursor_col),
        .o_cursor_row     (o_cursor_row),
        .o_read_char      (o_read_char),
        .o_read_attribute (o_read_attribute),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void blank_grid();
        for (int i = 0; i < CELLS; i++) grid_model[i] = CHAR_BLANK;
        cur_col = 0;
        cur_row = 0;
    endfunction

    // next row, scrolling the grid up at the bottom
    function automatic void advance_row();
        if (cur_row < ROWS - 1) begin
            cur_row++;
        end else begin
            for (int i = 0; i < CELLS - COLS; i++) grid_model[i] = grid_model[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++) grid_model[i] = CHAR_BLANK;
        end
    endfunction

    function automatic t_cursor_report console_apply(t_console_cmd c);
        t_cursor_report r;
        int at;
        r = '0;
        case (c.func)
            FUNC_PUT: begin
                if (c.ch == CHAR_LF || c.ch == CHAR_CR) begin
                    advance_row();
                    cur_col = 0;
                end else if (c.ch != CHAR_NUL) begin
                    grid_model[cur_row * COLS + cur_col] = c.ch;
                    cur_col++;
                    if (cur_col >= COLS) begin
                        cur_col = 0;
                        advance_row();
                    end
                end
            end
            FUNC_BACK: begin
                if (cur_col > 0) begin
                    cur_col--;
                end else if (cur_row > 0) begin
                    cur_col = COLS - 1;
                    cur_row--;
                end
                grid_model[cur_row * COLS + cur_col] = c.ch;
            end
            FUNC_CLEAR: begin
                blank_grid();
            end
            default: begin
                if (c.idx < CELLS) begin
                    r.rd_char = grid_model[c.idx];
                    r.rd_attr = attr_model;
                end
            end
        endcase
        at = cur_row * COLS + cur_col;
        r.pos = at[POS_W-1:0];
        r.col = cur_col[OCOL_W-1:0];
        r.row = cur_row[OROW_W-1:0];
        return r;
    endfunction

    // mostly short idle stretches, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic void check_field(string name, int expv, int actv);
        if (expv != actv) begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            mismatches++;
        end
    endfunction

    function automatic void push_cmd(t_func f, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
        t_console_cmd c;
        c.func = f;
        c.ch   = ch;
        c.idx  = idx;
        pending_cmds.push_back(c);
        queued_total++;
    endfunction

    // Mostly text lines (short ones, some long enough to wrap) ending in LF or CR,
    // with reads, back-put bursts, clears and fully random noise mixed in.
    function automatic void queue_console_traffic(int n);
        int target, kind, len, r, idx;
        target = queued_total + n;
        while (queued_total < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 85) : $urandom_range(0, 12);
                for (int k = 0; k < len; k++)
                    push_cmd(FUNC_PUT, CHAR_W'($urandom_range(1, 255)),
                             IDX_W'($urandom_range(0, 2047)));
                push_cmd(FUNC_PUT, $urandom_range(0, 1) ? CHAR_LF : CHAR_CR,
                         IDX_W'($urandom_range(0, 2047)));
            end else if (kind < 80) begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++) begin
                    r = $urandom_range(0, 9);
                    if (r < 6)      idx = $urandom_range(0, CELLS - 1);
                    else if (r < 8) idx = $urandom_range(CELLS - 5 * COLS, CELLS - 1);
                    else if (r < 9) idx = $urandom_range(0, COLS - 1);
                    else            idx = $urandom_range(CELLS, 2047);
                    push_cmd(FUNC_READ, CHAR_W'($urandom_range(0, 255)), IDX_W'(idx));
                end
            end else if (kind < 91) begin
                len = $urandom_range(1, 5);
                for (int k = 0; k < len; k++)
                    push_cmd(FUNC_BACK, CHAR_W'($urandom_range(0, 255)),
                             IDX_W'($urandom_range(0, 2047)));
            end else if (kind < 98) begin
                len = $urandom_range(1, 3);
                for (int k = 0; k < len; k++)
                    push_cmd(t_func'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                             IDX_W'($urandom_range(0, 2047)));
            end else begin
                push_cmd(FUNC_CLEAR, CHAR_W'($urandom_range(0, 255)),
                         IDX_W'($urandom_range(0, 2047)));
            end
        end
    endfunction

    always @(posedge i_clk) begin : cmd_driver
        t_console_cmd nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else if (!in_valid || !o_in_stall) begin
            if (in_valid)
                expected_reports.push_back(console_apply(drive_cmd));
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                nxt = pending_cmds.pop_front();
                drive_cmd <= nxt;
                in_valid  <= 1'b1;
                gap_left  <= (idle_on && $urandom_range(0, 99) < 30) ? idle_len() : 0;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : report_monitor
        t_cursor_report exp_r;
        int stall_left;
        int hold_left;
        if (!i_rst_n) begin
            out_stall  <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                results_seen++;
                if (expected_reports.size() == 0) begin
                    $error("result with no pending expectation: pos %0d", o_cursor_position);
                    mismatches++;
                end else begin
                    exp_r = expected_reports.pop_front();
                    check_field("cursor_position", int'(exp_r.pos), int'(o_cursor_position));
                    check_field("cursor_col", int'(exp_r.col), int'(o_cursor_col));
                    check_field("cursor_row", int'(exp_r.row), int'(o_cursor_row));
                    check_field("read_char", int'(exp_r.rd_char), int'(o_read_char));
                    check_field("read_attribute", int'(exp_r.rd_attr),
                                int'(o_read_attribute));
                end
                // long back-pressure so the block fills and stalls its input
                if (results_seen == 120 || results_seen == 900)
                    hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 99) < 25) begin
                stall_left = idle_len() - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // ends the run when no transfer happens on either side for too long
    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || in_valid || expected_reports.size() > 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_attribute(logic [ATTR_W-1:0] v);
        @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        attr_model  = v;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        blank_grid();
        attr_model = ATTR_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset attribute, read bounds, NUL handling, back-put wrap, clear
        push_cmd(FUNC_READ, 8'h00, 11'd0);
        push_cmd(FUNC_READ, 8'hFF, 11'd1999);
        push_cmd(FUNC_READ, 8'h00, 11'd2000);
        push_cmd(FUNC_READ, 8'h00, 11'd2047);
        push_cmd(FUNC_PUT, CHAR_NUL, 11'd2047);
        push_cmd(FUNC_BACK, CHAR_NUL, 11'd0);
        push_cmd(FUNC_READ, 8'h00, 11'd0);
        push_cmd(FUNC_PUT, 8'hFF, 11'd0);
        push_cmd(FUNC_PUT, 8'h41, 11'd0);
        push_cmd(FUNC_BACK, 8'h80, 11'd0);
        push_cmd(FUNC_READ, 8'h00, 11'd1);
        push_cmd(FUNC_PUT, CHAR_LF, 11'd0);
        push_cmd(FUNC_BACK, 8'h7E, 11'd0);
        push_cmd(FUNC_READ, 8'h00, 11'd79);
        push_cmd(FUNC_PUT, CHAR_CR, 11'd0);
        push_cmd(FUNC_PUT, 8'h01, 11'd0);
        push_cmd(FUNC_READ, 8'h00, 11'd80);
        push_cmd(FUNC_CLEAR, 8'hFF, 11'd2047);
        push_cmd(FUNC_READ, 8'h00, 11'd80);
        push_cmd(FUNC_READ, 8'h00, 11'd0);
        wait_drained();

        write_attribute(8'hFF);
        idle_on = 1'b1;
        queue_console_traffic(300);
        wait_drained();

        // a stretch with no gaps or stalls
        write_attribute(8'h00);
        idle_on = 1'b0;
        queue_console_traffic(300);
        wait_drained();

        write_attribute(ATTR_W'($urandom_range(1, 254)));
        idle_on = 1'b1;
        queue_console_traffic(300);
        wait_drained();

        write_attribute(8'hA5);
        queue_console_traffic(300);
        wait_drained();

        repeat (30) @(negedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_ctrl.sv
rtl/core/tcw_datapath.sv
rtl/core/text_console_writer.sv
rtl/core/tcw_check.sv
tb/tb_text_console_writer.sv
